// ===== rtl/core/pepg_pkg.sv =====
`default_nettype none

package pepg_pkg;

    // field widths fixed by the interface
    localparam int WIN_BITS     = 20;
    localparam int ID_BITS      = 32;
    localparam int CFG_IDX_BITS = 2;

    // default geometry
    localparam int DEF_X_BITS    = 5;
    localparam int DEF_Y_BITS    = 5;
    localparam int DEF_TIME_BITS = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_POST_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRE_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PILEUP_WINDOW = 2'd2;

    // window reset values in ticks
    localparam logic [WIN_BITS-1:0] POST_WINDOW_RST   = 20'd8192;
    localparam logic [WIN_BITS-1:0] PRE_WINDOW_RST    = 20'd512;
    localparam logic [WIN_BITS-1:0] PILEUP_WINDOW_RST = 20'd16;

    // transaction modes
    localparam logic MODE_EVENT = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // class of the gap to a same-pixel neighbor
    typedef enum logic [1:0] {
        GAP_NONE   = 2'd0,
        GAP_NEAR   = 2'd1,
        GAP_SHORT  = 2'd2,
        GAP_PILEUP = 2'd3
    } gap_class_t;

    typedef enum logic [1:0] {
        GRADE_ISOLATED = 2'd0,
        GRADE_FOLLOWED = 2'd1,
        GRADE_SHORT    = 2'd2,
        GRADE_PILEUP   = 2'd3
    } grade_t;

    typedef struct packed {
        logic [WIN_BITS-1:0] post_window;
        logic [WIN_BITS-1:0] pre_window;
        logic [WIN_BITS-1:0] pileup_window;
    } window_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [ID_BITS-1:0]  graded_id;
        grade_t              grade;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/pepg_state_mem.sv =====
`default_nettype none

module pepg_state_mem #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 84
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    output logic                      busy
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem_array [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS:0]   clr_cnt_reg;

    assign busy    = !clr_cnt_reg[ADDR_BITS];
    assign rd_data = rd_data_reg;

    // clearing sweep after reset, one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (busy) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // write port, with the clearing sweep taking priority
    always_ff @(posedge aclk) begin
        if (busy) begin
            mem_array[clr_cnt_reg[ADDR_BITS-1:0]] <= '0;
        end else if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // registered read, forwarding a same-cycle write to the same entry
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem_array[rd_addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pepg_update.sv =====
`default_nettype none

module pepg_update #(
    parameter int TIME_BITS = pepg_pkg::DEF_TIME_BITS
) (
    input  wire logic                         in_mode,
    input  wire logic [TIME_BITS-1:0]         in_time,
    input  wire logic [pepg_pkg::ID_BITS-1:0] in_id,
    input  wire pepg_pkg::window_cfg_t        cfg,
    input  wire logic                         old_seen,
    input  wire logic                         old_pending,
    input  wire logic [1:0]                   old_class,
    input  wire logic [pepg_pkg::ID_BITS-1:0] old_id,
    input  wire logic [TIME_BITS-1:0]         old_time,
    output pepg_pkg::result_t                 res,
    output logic                              wr_en,
    output logic                              new_seen,
    output logic                              new_pending,
    output logic [1:0]                        new_class,
    output logic [pepg_pkg::ID_BITS-1:0]      new_id,
    output logic [TIME_BITS-1:0]              new_time
);

    import pepg_pkg::*;

    localparam int CMP_BITS = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;

    function automatic grade_t grade_of(gap_class_t back_cls, gap_class_t fwd_cls);
        grade_t g;
        if (back_cls == GAP_PILEUP || fwd_cls == GAP_PILEUP) begin
            g = GRADE_PILEUP;
        end else if (back_cls == GAP_SHORT || fwd_cls == GAP_SHORT) begin
            g = GRADE_SHORT;
        end else if (fwd_cls == GAP_NEAR) begin
            g = GRADE_FOLLOWED;
        end else begin
            g = GRADE_ISOLATED;
        end
        return g;
    endfunction

    logic [TIME_BITS-1:0] gap;
    logic [CMP_BITS-1:0]  gap_ext;
    logic [CMP_BITS-1:0]  post_ext;
    logic [CMP_BITS-1:0]  pre_ext;
    logic [CMP_BITS-1:0]  pileup_ext;
    gap_class_t           cls;
    gap_class_t           before_cls;

    // backward gap, clamped at zero if time runs backwards
    assign gap        = (in_time >= old_time) ? (in_time - old_time) : '0;
    assign gap_ext    = CMP_BITS'(gap);
    assign post_ext   = CMP_BITS'(cfg.post_window);
    assign pre_ext    = CMP_BITS'(cfg.pre_window);
    assign pileup_ext = CMP_BITS'(cfg.pileup_window);
    assign before_cls = gap_class_t'(old_class);

    // classify the gap to the previous event on this pixel
    always_comb begin
        if (!old_seen || (gap_ext > post_ext)) begin
            cls = GAP_NONE;
        end else if (gap_ext < pileup_ext) begin
            cls = GAP_PILEUP;
        end else if (gap_ext < pre_ext) begin
            cls = GAP_SHORT;
        end else begin
            cls = GAP_NEAR;
        end
    end

    // finalize the pending event and build the new entry
    always_comb begin
        res.valid     = old_pending;
        res.graded_id = old_id;
        new_seen      = old_seen;
        new_pending   = old_pending;
        new_class     = old_class;
        new_id        = old_id;
        new_time      = old_time;
        if (in_mode == MODE_FLUSH) begin
            res.grade   = grade_of(before_cls, GAP_NONE);
            wr_en       = old_pending;
            new_pending = 1'b0;
        end else begin
            res.grade   = grade_of(before_cls, cls);
            wr_en       = 1'b1;
            new_seen    = 1'b1;
            new_pending = 1'b1;
            new_class   = cls;
            new_id      = in_id;
            new_time    = in_time;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pixel_event_pileup_grader.sv =====
`default_nettype none

// an accepted transaction is registered in stage 1, its result in the output register;
// throughput: one transaction per cycle unless output stalls, set by one read-modify-write
// of the per-pixel state memory with write-to-read forwarding for back-to-back transactions
// reset: windows return to their defaults; the pixel state memory is then swept clear,
// one entry per cycle, 2**(X_BITS+Y_BITS) entries (1024 at default), s_ready low meanwhile
module pixel_event_pileup_grader #(
    parameter int X_BITS    = pepg_pkg::DEF_X_BITS,
    parameter int Y_BITS    = pepg_pkg::DEF_Y_BITS,
    parameter int TIME_BITS = pepg_pkg::DEF_TIME_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pepg_pkg::CFG_IDX_BITS-1:0] cfg_wr_index,
    input  wire logic [pepg_pkg::WIN_BITS-1:0]     cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_mode,
    input  wire logic [X_BITS-1:0]                 s_pixel_x,
    input  wire logic [Y_BITS-1:0]                 s_pixel_y,
    input  wire logic [TIME_BITS-1:0]              s_event_time,
    input  wire logic [pepg_pkg::ID_BITS-1:0]      s_event_id,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pepg_pkg::ID_BITS-1:0]           m_graded_id,
    output logic [1:0]                             m_grade
);

    import pepg_pkg::*;

    localparam int ADDR_BITS  = X_BITS + Y_BITS;
    localparam int ENTRY_BITS = 4 + ID_BITS + TIME_BITS;
    localparam int CLASS_LSB  = TIME_BITS + ID_BITS;

    window_cfg_t window_cfg_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_mode_reg;
    logic [ADDR_BITS-1:0] s1_addr_reg;
    logic [TIME_BITS-1:0] s1_time_reg;
    logic [ID_BITS-1:0]   s1_id_reg;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [ID_BITS-1:0]   m_graded_id_reg;
    logic [1:0]           m_grade_reg;

    logic                  s_fire;
    logic                  s1_fire;
    logic                  out_free;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ENTRY_BITS-1:0] mem_rd_data;
    logic [ENTRY_BITS-1:0] mem_wr_data;
    logic                  mem_wr_en;
    logic                  mem_busy;

    result_t              res;
    logic                 upd_wr_en;
    logic                 new_seen;
    logic                 new_pending;
    logic [1:0]           new_class;
    logic [ID_BITS-1:0]   new_id;
    logic [TIME_BITS-1:0] new_time;

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && (!res.valid || out_free);
    assign s_ready  = !mem_busy && (!s1_valid_reg || s1_fire);
    assign s_fire   = s_valid && s_ready;
    assign rd_addr  = {s_pixel_y, s_pixel_x};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_cfg_reg.post_window   <= POST_WINDOW_RST;
            window_cfg_reg.pre_window    <= PRE_WINDOW_RST;
            window_cfg_reg.pileup_window <= PILEUP_WINDOW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_POST_WINDOW:   window_cfg_reg.post_window   <= cfg_wr_data;
                CFG_PRE_WINDOW:    window_cfg_reg.pre_window    <= cfg_wr_data;
                CFG_PILEUP_WINDOW: window_cfg_reg.pileup_window <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // per-pixel state memory
    pepg_state_mem #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (mem_wr_data),
        .busy    (mem_busy)
    );

    // stage 1 holds the transaction whose entry is being read
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_mode_reg <= s_mode;
            s1_addr_reg <= rd_addr;
            s1_time_reg <= s_event_time;
            s1_id_reg   <= s_event_id;
        end
    end

    // grading and entry update
    pepg_update #(
        .TIME_BITS (TIME_BITS)
    ) u_update (
        .in_mode     (s1_mode_reg),
        .in_time     (s1_time_reg),
        .in_id       (s1_id_reg),
        .cfg         (window_cfg_reg),
        .old_seen    (mem_rd_data[CLASS_LSB+3]),
        .old_pending (mem_rd_data[CLASS_LSB+2]),
        .old_class   (mem_rd_data[CLASS_LSB +: 2]),
        .old_id      (mem_rd_data[TIME_BITS +: ID_BITS]),
        .old_time    (mem_rd_data[TIME_BITS-1:0]),
        .res         (res),
        .wr_en       (upd_wr_en),
        .new_seen    (new_seen),
        .new_pending (new_pending),
        .new_class   (new_class),
        .new_id      (new_id),
        .new_time    (new_time)
    );

    assign mem_wr_en   = s1_fire && upd_wr_en;
    assign mem_wr_data = {new_seen, new_pending, new_class, new_id, new_time};

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_fire && res.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && res.valid) begin
            m_graded_id_reg <= res.graded_id;
            m_grade_reg     <= res.grade;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_graded_id = m_graded_id_reg;
    assign m_grade     = m_grade_reg;

    // back-to-back transactions on one pixel see the entry just written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && s_fire && (s1_addr_reg == rd_addr)) |=>
        (mem_rd_data == $past(mem_wr_data)))
        else $error("forwarded entry does not match the write");

    // no transaction taken while the state memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> !mem_busy)
        else $error("transaction accepted during clearing sweep");

    // a stalled result keeps stage 1 and its pixel in place
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && res.valid && !out_free) |=>
        (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stage 1 lost under backpressure");

    // a new result only comes from a transaction in stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a transaction");

endmodule

`default_nettype wire
